### rtl/core/tsq_pkg.sv
// shared types and constants for the touch sample calibrate queue
package tsq_pkg;

   // calibration arithmetic
   localparam int RAW_W     = 10;
   localparam int VAL_W     = 16;
   localparam int TICK_W    = 16;
   localparam int PROD_W    = 27;
   localparam int CAL_SHIFT = 10;
   localparam int CAL_ONE   = 1024;

   // command queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 30;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_SCALE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SCALE         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SCALE         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_ADJUST        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ADJUST        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLDS      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_WINDOW   = 3'd7;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_TICK   = 2'd1,
      KIND_POP    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_STORED      = 3'd0,
      STATUS_STORED_DROP = 3'd1,
      STATUS_DUPLICATE   = 3'd2,
      STATUS_POPPED      = 3'd3,
      STATUS_POP_EMPTY   = 3'd4,
      STATUS_TICK_TAKEN  = 3'd5
   } status_type;

   typedef struct packed {
      logic [VAL_W-1:0] pressure;
      logic [VAL_W-1:0] x;
      logic [VAL_W-1:0] y;
   } sample_type;

   typedef struct packed {
      sample_type        sample;
      logic [TICK_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      kind_type          kind;
      sample_type        held;
      logic [TICK_W-1:0] tick;
   } cmd_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] pressure_scale;
      logic signed [VAL_W-1:0] x_scale;
      logic signed [VAL_W-1:0] y_scale;
      logic        [VAL_W-1:0] pressure_offset;
      logic        [VAL_W-1:0] x_adjust;
      logic        [VAL_W-1:0] y_adjust;
      logic        [RAW_W-1:0] pressure_thr;
      logic        [RAW_W-1:0] x_thr;
      logic        [RAW_W-1:0] y_thr;
      logic        [TICK_W-1:0] repeat_window;
   } cfg_type;

   typedef struct packed {
      logic                  empty;
      logic [FIFO_CNT_W-1:0] count;
   } fifo_status_type;

endpackage

### rtl/core/tsq_ram.sv
// generic single write, single read ram with registered read data
module tsq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tsq_front.sv
// front end: takes requests, calibrates samples, keeps held sample and tick count
module tsq_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_kind,
   input  logic [tsq_pkg::RAW_W-1:0] req_raw_pressure,
   input  logic [tsq_pkg::RAW_W-1:0] req_raw_x,
   input  logic [tsq_pkg::RAW_W-1:0] req_raw_y,
   input  tsq_pkg::cfg_type         cfg,
   input  tsq_pkg::fifo_status_type fifo_status,
   output logic                     push,
   output tsq_pkg::cmd_type         push_cmd
);
   import tsq_pkg::*;

   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(CAL_ONE - 1);

   logic                     accept;
   logic                     s1_valid_ff, s1_valid_in;
   logic [1:0]               s1_kind_ff;
   logic signed [PROD_W-1:0] p_prod_ff, x_prod_ff, y_prod_ff;
   logic                     p_hit_ff, x_hit_ff, y_hit_ff;
   sample_type               held_ff, held_in;
   logic [TICK_W-1:0]        tick_ff, tick_in;

   // divide by 1024 toward zero, add offset, keep low 16 bits
   function automatic logic [VAL_W-1:0] calib(input logic signed [PROD_W-1:0] prod,
                                              input logic [VAL_W-1:0] offset);
      logic signed [PROD_W-1:0] biased;
      logic        [VAL_W-1:0]  q;
      biased = prod + (prod[PROD_W-1] ? ROUND_BIAS : PROD_W'(0));
      q = VAL_W'(biased >>> CAL_SHIFT);
      return q + offset;
   endfunction

   // hold off when the queue could overflow with what is in flight
   always_comb begin
      busy   = (fifo_status.count + FIFO_CNT_W'(s1_valid_ff)) >= FIFO_CNT_W'(FIFO_DEPTH);
      accept = start && !busy;
      s1_valid_in = accept;
   end

   // stage one: products and threshold compares
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= req_kind;
         p_prod_ff  <= PROD_W'($signed({1'b0, req_raw_pressure}) * cfg.pressure_scale);
         x_prod_ff  <= PROD_W'($signed({1'b0, req_raw_x}) * cfg.x_scale);
         y_prod_ff  <= PROD_W'($signed({1'b0, req_raw_y}) * cfg.y_scale);
         p_hit_ff   <= req_raw_pressure > cfg.pressure_thr;
         x_hit_ff   <= req_raw_x > cfg.x_thr;
         y_hit_ff   <= req_raw_y > cfg.y_thr;
      end
   end

   // stage two: classify, update held sample and tick, push command
   always_comb begin
      held_in  = held_ff;
      tick_in  = tick_ff;
      push     = 1'b0;
      push_cmd.kind = KIND_SAMPLE;
      push_cmd.tick = tick_ff;
      if (s1_valid_ff) begin
         case (s1_kind_ff)
            KIND_SAMPLE: begin
               if (p_hit_ff) begin
                  held_in.pressure = calib(p_prod_ff, cfg.pressure_offset);
               end
               if (x_hit_ff) begin
                  held_in.x = calib(x_prod_ff, cfg.x_adjust);
               end
               if (y_hit_ff) begin
                  held_in.y = calib(y_prod_ff, cfg.y_adjust);
               end
               push = 1'b1;
               push_cmd.kind = KIND_SAMPLE;
            end
            KIND_TICK: begin
               tick_in = tick_ff + 1'b1;
               push = 1'b1;
               push_cmd.kind = KIND_TICK;
            end
            KIND_POP: begin
               push = 1'b1;
               push_cmd.kind = KIND_POP;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
      push_cmd.held = held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         tick_ff <= '0;
      end else begin
         held_ff <= held_in;
         tick_ff <= tick_in;
      end
   end

endmodule

### rtl/core/tsq_cmd_fifo.sv
// short command queue between front and back
module tsq_cmd_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tsq_pkg::cmd_type         push_cmd,
   input  logic                     pop,
   output tsq_pkg::cmd_type         head,
   output tsq_pkg::fifo_status_type status
);
   import tsq_pkg::*;

   cmd_type               slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wptr_ff, wptr_in;
   logic [FIFO_PTR_W-1:0] rptr_ff, rptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_pop;

   // pointer and count update
   always_comb begin
      do_pop   = pop && (count_ff != '0);
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
      head     = slot_ff[rptr_ff];
      status.empty = (count_ff == '0);
      status.count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/tsq_back.sv
// back end: ring queue in ram, duplicate check, pops and result register
module tsq_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tsq_pkg::cmd_type          head,
   input  tsq_pkg::fifo_status_type  fifo_status,
   output logic                      pop,
   input  logic [tsq_pkg::TICK_W-1:0] repeat_window,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_status,
   output tsq_pkg::sample_type       rsp_sample,
   output logic [3:0]                rsp_queued
);
   import tsq_pkg::*;

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = (IW + 1 > 4) ? IW + 1 : 4;
   localparam int EW = $bits(entry_type);

   typedef enum logic [2:0] {
      B_IDLE  = 3'b001,
      B_CHECK = 3'b010,
      B_POP   = 3'b100
   } bstate_type;

   bstate_type        state_ff, state_in;
   logic [IW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   cmd_type           cmd_ff, cmd_in;
   logic              ram_we;
   logic [IW-1:0]     ram_waddr, ram_raddr;
   entry_type         ram_wdata, ram_rdata;
   logic [EW-1:0]     ram_rbits;
   logic              emit, dup, is_empty;
   logic [TICK_W-1:0] age;
   status_type        status_in;
   sample_type        sample_in;
   logic              valid_ff;
   status_type        status_ff;
   sample_type        sample_ff;
   logic [3:0]        queued_ff;

   function automatic logic [IW-1:0] inc(input logic [IW-1:0] i);
      return (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IW-1:0] dec(input logic [IW-1:0] i);
      return (i == '0) ? IW'(QUEUE_DEPTH - 1) : i - 1'b1;
   endfunction

   // entries held, low four bits
   function automatic logic [3:0] count_low(input logic [IW-1:0] w, input logic [IW-1:0] r);
      logic [CW-1:0] diff;
      diff = CW'(w) - CW'(r);
      if (w < r) begin
         diff = diff + CW'(QUEUE_DEPTH);
      end
      return diff[3:0];
   endfunction

   tsq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rbits)
   );

   assign ram_rdata = entry_type'(ram_rbits);

   // sequencer: dispatch from the command queue, then check or pop
   always_comb begin
      state_in  = state_ff;
      wr_in     = wr_ff;
      rd_in     = rd_ff;
      cmd_in    = cmd_ff;
      pop       = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = wr_ff;
      ram_wdata = '{sample: cmd_ff.held, stamp: cmd_ff.tick};
      ram_raddr = rd_ff;
      emit      = 1'b0;
      status_in = STATUS_STORED;
      sample_in = cmd_ff.held;
      is_empty  = (wr_ff == rd_ff);
      age       = cmd_ff.tick - ram_rdata.stamp;
      dup       = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!fifo_status.empty) begin
               pop    = 1'b1;
               cmd_in = head;
               case (head.kind)
                  KIND_TICK: begin
                     emit      = 1'b1;
                     status_in = STATUS_TICK_TAKEN;
                     sample_in = head.held;
                  end
                  KIND_POP: begin
                     if (is_empty) begin
                        emit      = 1'b1;
                        status_in = STATUS_POP_EMPTY;
                        sample_in = '0;
                     end else begin
                        ram_raddr = rd_ff;
                        state_in  = B_POP;
                     end
                  end
                  KIND_SAMPLE: begin
                     sample_in = head.held;
                     if (is_empty) begin
                        ram_we    = 1'b1;
                        ram_waddr = wr_ff;
                        ram_wdata = '{sample: head.held, stamp: head.tick};
                        wr_in     = inc(wr_ff);
                        emit      = 1'b1;
                        status_in = STATUS_STORED;
                     end else begin
                        ram_raddr = dec(wr_ff);
                        state_in  = B_CHECK;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         B_CHECK: begin
            dup      = (ram_rdata.sample == cmd_ff.held) && (age < repeat_window);
            emit     = 1'b1;
            state_in = B_IDLE;
            if (dup) begin
               status_in = STATUS_DUPLICATE;
            end else begin
               ram_we = 1'b1;
               wr_in  = inc(wr_ff);
               if (inc(wr_ff) == rd_ff) begin
                  rd_in     = inc(rd_ff);
                  status_in = STATUS_STORED_DROP;
               end else begin
                  status_in = STATUS_STORED;
               end
            end
         end
         B_POP: begin
            emit      = 1'b1;
            status_in = STATUS_POPPED;
            sample_in = ram_rdata.sample;
            rd_in     = inc(rd_ff);
            state_in  = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         wr_ff    <= '0;
         rd_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         valid_ff <= emit;
      end
   end

   // command and result payload
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit) begin
         status_ff <= status_in;
         sample_ff <= sample_in;
         queued_ff <= count_low(wr_in, rd_in);
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_sample = sample_ff;
   assign rsp_queued = queued_ff;

endmodule

### rtl/core/touch_sample_calibrate_queue_core.sv
// top level: csr registers, front end, command queue and back end
// result path (empty command queue): stage one, command queue slot, result register for
// ticks, empty pops, samples into an empty queue; others add the ram check or pop state
// throughput: 1 transaction per cycle unless busy; checked samples and pops add a ram read
// busy rises when the 4-entry command queue cannot take what is in flight
// reset: identity calibration, indices, held sample, ticks cleared; ram kept; no rsp stall
module touch_sample_calibrate_queue_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_kind,
   input  logic [tsq_pkg::RAW_W-1:0]     req_raw_pressure,
   input  logic [tsq_pkg::RAW_W-1:0]     req_raw_x,
   input  logic [tsq_pkg::RAW_W-1:0]     req_raw_y,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [tsq_pkg::VAL_W-1:0]     rsp_out_pressure,
   output logic [tsq_pkg::VAL_W-1:0]     rsp_out_x,
   output logic [tsq_pkg::VAL_W-1:0]     rsp_out_y,
   output logic [3:0]                    rsp_queued,
   input  logic                          csr_we,
   input  logic [tsq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tsq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tsq_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            push, fifo_pop;
   cmd_type         push_cmd, fifo_head;
   fifo_status_type fifo_status;
   sample_type      rsp_sample;

   // csr write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PRESSURE_SCALE:  cfg_in.pressure_scale  = csr_wdata[VAL_W-1:0];
            CSR_X_SCALE:         cfg_in.x_scale         = csr_wdata[VAL_W-1:0];
            CSR_Y_SCALE:         cfg_in.y_scale         = csr_wdata[VAL_W-1:0];
            CSR_PRESSURE_OFFSET: cfg_in.pressure_offset = csr_wdata[VAL_W-1:0];
            CSR_X_ADJUST:        cfg_in.x_adjust        = csr_wdata[VAL_W-1:0];
            CSR_Y_ADJUST:        cfg_in.y_adjust        = csr_wdata[VAL_W-1:0];
            CSR_THRESHOLDS: begin
               cfg_in.pressure_thr = csr_wdata[RAW_W-1:0];
               cfg_in.x_thr        = csr_wdata[2*RAW_W-1:RAW_W];
               cfg_in.y_thr        = csr_wdata[3*RAW_W-1:2*RAW_W];
            end
            CSR_REPEAT_WINDOW:   cfg_in.repeat_window   = csr_wdata[TICK_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressure_scale  <= VAL_W'(CAL_ONE);
         cfg_ff.x_scale         <= VAL_W'(CAL_ONE);
         cfg_ff.y_scale         <= VAL_W'(CAL_ONE);
         cfg_ff.pressure_offset <= '0;
         cfg_ff.x_adjust        <= '0;
         cfg_ff.y_adjust        <= '0;
         cfg_ff.pressure_thr    <= '0;
         cfg_ff.x_thr           <= '0;
         cfg_ff.y_thr           <= '0;
         cfg_ff.repeat_window   <= TICK_W'(30);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_raw_pressure (req_raw_pressure),
      .req_raw_x        (req_raw_x),
      .req_raw_y        (req_raw_y),
      .cfg              (cfg_ff),
      .fifo_status      (fifo_status),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   tsq_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (fifo_pop),
      .head     (fifo_head),
      .status   (fifo_status)
   );

   tsq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (fifo_head),
      .fifo_status   (fifo_status),
      .pop           (fifo_pop),
      .repeat_window (cfg_ff.repeat_window),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_sample    (rsp_sample),
      .rsp_queued    (rsp_queued)
   );

   assign rsp_out_pressure = rsp_sample.pressure;
   assign rsp_out_x        = rsp_sample.x;
   assign rsp_out_y        = rsp_sample.y;

endmodule
